>>> hdl/dit_pkg.sv
package dit_pkg;

  // request kinds carried in s_tuser
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;

  // register numbers
  localparam logic [3:0] REG_PORT_A = 4'd0;
  localparam logic [3:0] REG_PORT_B = 4'd1;
  localparam logic [3:0] REG_DDR_A  = 4'd2;
  localparam logic [3:0] REG_DDR_B  = 4'd3;
  localparam logic [3:0] REG_TA_LO  = 4'd4;
  localparam logic [3:0] REG_TA_HI  = 4'd5;
  localparam logic [3:0] REG_TB_LO  = 4'd6;
  localparam logic [3:0] REG_TB_HI  = 4'd7;
  localparam logic [3:0] REG_ICR    = 4'd13;
  localparam logic [3:0] REG_CRA    = 4'd14;
  localparam logic [3:0] REG_CRB    = 4'd15;

  // configuration register indexes
  localparam logic CFG_MASKABLE   = 1'b0;
  localparam logic CFG_PORT_ZERO  = 1'b1;

  localparam int unsigned RegCount = 16;
  localparam logic [15:0] LATCH_RESET = 16'hFFFF;

  // control register bits
  localparam int unsigned CR_START   = 0;
  localparam int unsigned CR_ONESHOT = 3;
  localparam int unsigned ICR_ANY    = 7;

  typedef struct packed {
    logic [15:0] count;
    logic [7:0]  ctrl;
    logic        fired;
  } timer_res_t;

  typedef struct packed {
    logic       pending;
    logic       nmi;
    logic       irq;
    logic [7:0] read_data;
  } result_t;

endpackage

>>> hdl/dual_interval_timer_with_irq.sv
// channel   | direction | contents
// ----------+-----------+-------------------------------------------------
// s_*       | in        | tuser: req_type; tdata: reg_addr, write_data,
//           |           |   tick_count
// m_*       | out       | tdata: read_data, irq_pulse, nmi_pulse,
//           |           |   interrupt_pending
// cfg_*     | in        | index 0 maskable, index 1 port_reads_zero
//
// one item per cycle sustained while the output is not stalled; after its transfer a result
// passes the input register, then the result register
// the limit per cycle is the timer path: a 17-bit subtract feeding a 16-bit reload add
// rst is synchronous: timers stopped, latches all ones, mask and flags clear
// a stalled output holds its result while one more item waits in the input register
module dual_interval_timer_with_irq (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // reg_addr[3:0], write_data[11:4], tick_count[27:12]
  input  logic [1:0]  s_tuser,   // req_type[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // read_data[7:0], irq_pulse[8], nmi_pulse[9],
                                 // interrupt_pending[10]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic        cfg_data
);

  logic        in_valid;
  logic [1:0]  in_req;
  logic [3:0]  in_addr;
  logic [7:0]  in_wdata;
  logic [15:0] in_cycles;
  logic        advance;
  logic        maskable;
  logic        port_reads_zero;

  dit_pkg::result_t step_res;
  dit_pkg::result_t out_res;

  assign advance   = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      maskable        <= 1'b1;
      port_reads_zero <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        dit_pkg::CFG_MASKABLE:  maskable        <= cfg_data;
        dit_pkg::CFG_PORT_ZERO: port_reads_zero <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_req    <= s_tuser;
      in_addr   <= s_tdata[3:0];
      in_wdata  <= s_tdata[11:4];
      in_cycles <= s_tdata[27:12];
    end
  end

  dit_regs u_regs (
    .clk             (clk),
    .rst             (rst),
    .step            (advance),
    .req_type        (in_req),
    .reg_addr        (in_addr),
    .write_data      (in_wdata),
    .tick_count      (in_cycles),
    .maskable        (maskable),
    .port_reads_zero (port_reads_zero),
    .res             (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign m_tdata = {5'd0, out_res};

`ifndef ASSERT_OFF
  a_one_line: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(out_res.irq && out_res.nmi))
    else $error("irq and nmi raised together");

  a_pulse_pending: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (out_res.irq || out_res.nmi)) |-> out_res.pending)
    else $error("interrupt pulse without pending state");
`endif

endmodule

>>> hdl/dit_timer.sv
module dit_timer (
  input  logic [7:0]          ctrl,
  input  logic [15:0]         count,
  input  logic [15:0]         latch,
  input  logic [15:0]         cycles,
  input  logic                mask_bit,
  output dit_pkg::timer_res_t res
);

  logic [16:0] diff;
  logic        hit;

  // borrow out or exact zero means the counter reached zero
  assign diff = {1'b0, count} - {1'b0, cycles};
  assign hit  = diff[16] | (diff[15:0] == 16'd0);

  always_comb begin
    res.count = count;
    res.ctrl  = ctrl;
    res.fired = 1'b0;
    if (ctrl[dit_pkg::CR_START]) begin
      if (!hit) begin
        res.count = diff[15:0];
      end else begin
        res.fired = mask_bit;
        if (ctrl[dit_pkg::CR_ONESHOT]) begin
          res.count = 16'd0;
          res.ctrl[dit_pkg::CR_START] = 1'b0;
        end else begin
          // reload once, wrapping to 16 bits
          res.count = diff[15:0] + latch;
        end
      end
    end
  end

endmodule

>>> hdl/dit_regs.sv
module dit_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [1:0]          req_type,
  input  logic [3:0]          reg_addr,
  input  logic [7:0]          write_data,
  input  logic [15:0]         tick_count,
  input  logic                maskable,
  input  logic                port_reads_zero,
  output dit_pkg::result_t    res
);

  logic [7:0]  regs [dit_pkg::RegCount];
  logic [15:0] latch_a;
  logic [15:0] latch_b;
  logic [6:0]  irq_mask;
  logic        pending;
  logic        pending_next;

  dit_pkg::timer_res_t ta;
  dit_pkg::timer_res_t tb;
  logic                fired;
  logic [7:0]          port_val;

  dit_timer u_timer_a (
    .ctrl     (regs[dit_pkg::REG_CRA]),
    .count    ({regs[dit_pkg::REG_TA_HI], regs[dit_pkg::REG_TA_LO]}),
    .latch    (latch_a),
    .cycles   (tick_count),
    .mask_bit (irq_mask[0]),
    .res      (ta)
  );

  dit_timer u_timer_b (
    .ctrl     (regs[dit_pkg::REG_CRB]),
    .count    ({regs[dit_pkg::REG_TB_HI], regs[dit_pkg::REG_TB_LO]}),
    .latch    (latch_b),
    .cycles   (tick_count),
    .mask_bit (irq_mask[1]),
    .res      (tb)
  );

  assign fired = (req_type == dit_pkg::REQ_TICK) && (ta.fired || tb.fired);

  // input pins read back as ones where the direction bit is clear
  assign port_val = reg_addr[0] ? (regs[dit_pkg::REG_PORT_B] | ~regs[dit_pkg::REG_DDR_B])
                                : (regs[dit_pkg::REG_PORT_A] | ~regs[dit_pkg::REG_DDR_A]);

  always_comb begin
    pending_next = pending;
    if (fired) begin
      pending_next = 1'b1;
    end else if (req_type == dit_pkg::REQ_READ && reg_addr == dit_pkg::REG_ICR) begin
      pending_next = 1'b0;
    end
  end

  always_comb begin
    res.read_data = 8'd0;
    if (req_type == dit_pkg::REQ_READ) begin
      if (reg_addr == dit_pkg::REG_PORT_A || reg_addr == dit_pkg::REG_PORT_B) begin
        res.read_data = port_reads_zero ? 8'd0 : port_val;
      end else begin
        res.read_data = regs[reg_addr];
      end
    end
    res.irq     = fired && maskable;
    res.nmi     = fired && !maskable;
    res.pending = pending_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < dit_pkg::RegCount; i++) begin
        regs[4'(i)] <= 8'd0;
      end
      latch_a  <= dit_pkg::LATCH_RESET;
      latch_b  <= dit_pkg::LATCH_RESET;
      irq_mask <= 7'd0;
      pending  <= 1'b0;
    end else if (step) begin
      pending <= pending_next;
      case (req_type)
        dit_pkg::REQ_TICK: begin
          regs[dit_pkg::REG_TA_LO] <= ta.count[7:0];
          regs[dit_pkg::REG_TA_HI] <= ta.count[15:8];
          regs[dit_pkg::REG_CRA]   <= ta.ctrl;
          regs[dit_pkg::REG_TB_LO] <= tb.count[7:0];
          regs[dit_pkg::REG_TB_HI] <= tb.count[15:8];
          regs[dit_pkg::REG_CRB]   <= tb.ctrl;
          if (fired) begin
            regs[dit_pkg::REG_ICR] <= regs[dit_pkg::REG_ICR] |
                                      {1'b1, 5'd0, tb.fired, ta.fired};
          end
        end
        dit_pkg::REQ_READ: begin
          if (reg_addr == dit_pkg::REG_ICR) begin
            regs[dit_pkg::REG_ICR] <= 8'd0;
          end
        end
        dit_pkg::REQ_WRITE: begin
          unique case (reg_addr)
            dit_pkg::REG_TA_LO: latch_a[7:0]  <= write_data;
            dit_pkg::REG_TA_HI: latch_a[15:8] <= write_data;
            dit_pkg::REG_TB_LO: latch_b[7:0]  <= write_data;
            dit_pkg::REG_TB_HI: latch_b[15:8] <= write_data;
            dit_pkg::REG_ICR: begin
              // bit 7 picks set or clear for the mask bits given
              if (write_data[7]) begin
                irq_mask <= irq_mask | write_data[6:0];
              end else begin
                irq_mask <= irq_mask & ~write_data[6:0];
              end
            end
            dit_pkg::REG_CRA: begin
              if (write_data[dit_pkg::CR_START] && !regs[dit_pkg::REG_CRA][dit_pkg::CR_START]) begin
                regs[dit_pkg::REG_TA_LO] <= latch_a[7:0];
                regs[dit_pkg::REG_TA_HI] <= latch_a[15:8];
              end
              regs[dit_pkg::REG_CRA] <= write_data;
            end
            dit_pkg::REG_CRB: begin
              if (write_data[dit_pkg::CR_START] && !regs[dit_pkg::REG_CRB][dit_pkg::CR_START]) begin
                regs[dit_pkg::REG_TB_LO] <= latch_b[7:0];
                regs[dit_pkg::REG_TB_HI] <= latch_b[15:8];
              end
              regs[dit_pkg::REG_CRB] <= write_data;
            end
            default: regs[reg_addr] <= write_data;
          endcase
        end
        default: ;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_pending_flag: assert property (@(posedge clk) disable iff (rst)
    pending |-> regs[dit_pkg::REG_ICR][dit_pkg::ICR_ANY])
    else $error("pending interrupt without summary flag");

  a_icr_read_clears: assert property (@(posedge clk) disable iff (rst)
    (step && req_type == dit_pkg::REQ_READ && reg_addr == dit_pkg::REG_ICR)
    |=> (!pending && regs[dit_pkg::REG_ICR] == 8'd0))
    else $error("flag read did not clear flags and pending");
`endif

endmodule
